/* rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/usd_pkg.sv */
// ---------------------------------------------------------------------------
// UTF-8 stream decoder package
// Status codes and field widths shared by the decoder and its checker.
// ---------------------------------------------------------------------------
package usd_pkg;

   localparam int unsigned CP_W  = 31;
   localparam int unsigned LEN_W = 3;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BAD_LEAD  = 2'd1,
      STATUS_TRUNCATED = 2'd2
   } status_type;

   localparam logic [LEN_W-1:0] MAX_SEQ_LEN = 3'd6;

endpackage

/* rtl/utf8_stream_decoder.sv */
// ---------------------------------------------------------------------------
// UTF-8 stream decoder
// Decodes legacy UTF-8 with lead forms of one to six bytes, one word per cycle
// unless a held result stalls it; reports code point, sequence length, status.
// ---------------------------------------------------------------------------
//
//   channel   direction   handshake              payload
//   req       in          req_valid/req_ready    req_in_byte, req_end_of_buffer
//   rsp       out         rsp_valid/rsp_ready    rsp_code_point, rsp_seq_length,
//                                                rsp_status
//
// One word is taken per cycle unless the input register is held; a result
// passes from the input register to the output register, where it is valid.
// The decoder keeps the partial code point and the bytes still needed in
// registers that are updated as each word leaves the input register.
// A held result stalls only words that would produce a new result.
// Reset clears the input and output valid flags and returns the decoder
// to idle.
//
module utf8_stream_decoder
   import usd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_in_byte,
   input  logic                req_end_of_buffer,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [CP_W-1:0]     rsp_code_point,
   output logic [LEN_W-1:0]    rsp_seq_length,
   output logic [1:0]          rsp_status
);

   logic              in_valid_ff, in_valid_in;
   logic [7:0]        in_byte_ff;
   logic              in_eob_ff;

   logic [CP_W-1:0]   partial_ff, partial_in;
   logic [LEN_W-1:0]  remain_ff, remain_in;
   logic [LEN_W-1:0]  size_ff, size_in;

   logic              out_valid_ff, out_valid_in;
   logic [CP_W-1:0]   out_cp_ff;
   logic [LEN_W-1:0]  out_len_ff;
   status_type        out_status_ff;

   logic              emit;
   logic [CP_W-1:0]   emit_cp;
   logic [LEN_W-1:0]  emit_len;
   status_type        emit_status;
   logic              advance;
   logic [CP_W-1:0]   shifted;
   logic [LEN_W-1:0]  remain_dec;
   logic [LEN_W-1:0]  lead_len;
   logic [7:0]        lead_mask;
   logic              lead_bad;

   always_comb begin
      lead_len  = '0;
      lead_mask = '0;
      lead_bad  = 1'b0;
      unique casez (in_byte_ff)
         8'b0???????: begin lead_len = 3'd1; lead_mask = 8'h7F; end
         8'b110?????: begin lead_len = 3'd2; lead_mask = 8'h1F; end
         8'b1110????: begin lead_len = 3'd3; lead_mask = 8'h0F; end
         8'b11110???: begin lead_len = 3'd4; lead_mask = 8'h07; end
         8'b111110??: begin lead_len = 3'd5; lead_mask = 8'h03; end
         8'b1111110?: begin lead_len = 3'd6; lead_mask = 8'h01; end
         default:     begin lead_bad = 1'b1; end
      endcase
   end

   assign shifted    = {partial_ff[CP_W-7:0], in_byte_ff[5:0]};
   assign remain_dec = remain_ff - 3'd1;

   always_comb begin
      emit        = 1'b0;
      emit_cp     = '0;
      emit_len    = '0;
      emit_status = STATUS_OK;
      partial_in  = partial_ff;
      remain_in   = remain_ff;
      size_in     = size_ff;
      if (remain_ff != '0) begin
         if (remain_dec == '0) begin
            emit       = 1'b1;
            emit_cp    = shifted;
            emit_len   = size_ff;
            partial_in = '0;
            remain_in  = '0;
            size_in    = '0;
         end else if (in_eob_ff) begin
            emit        = 1'b1;
            emit_status = STATUS_TRUNCATED;
            partial_in  = '0;
            remain_in   = '0;
            size_in     = '0;
         end else begin
            partial_in = shifted;
            remain_in  = remain_dec;
         end
      end else if (lead_bad) begin
         emit        = 1'b1;
         emit_status = STATUS_BAD_LEAD;
      end else if (lead_len == 3'd1) begin
         emit     = 1'b1;
         emit_cp  = {{(CP_W-8){1'b0}}, in_byte_ff};
         emit_len = lead_len;
      end else if (in_eob_ff) begin
         emit        = 1'b1;
         emit_status = STATUS_TRUNCATED;
         partial_in  = '0;
         remain_in   = '0;
         size_in     = '0;
      end else begin
         partial_in = {{(CP_W-8){1'b0}}, in_byte_ff & lead_mask};
         remain_in  = lead_len - 3'd1;
         size_in    = lead_len;
      end
   end

   assign advance      = in_valid_ff && (!emit || !out_valid_ff || rsp_ready);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_valid || (in_valid_ff && !advance);
   assign out_valid_in = (advance && emit) || (out_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         partial_ff   <= '0;
         remain_ff    <= '0;
         size_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            partial_ff <= partial_in;
            remain_ff  <= remain_in;
            size_ff    <= size_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_eob_ff  <= req_end_of_buffer;
      end
      if (advance && emit) begin
         out_cp_ff     <= emit_cp;
         out_len_ff    <= emit_len;
         out_status_ff <= emit_status;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_code_point = out_cp_ff;
   assign rsp_seq_length = out_len_ff;
   assign rsp_status     = out_status_ff;

endmodule

/* rtl/usd_checker.sv */
// ---------------------------------------------------------------------------
// UTF-8 stream decoder checker
// Port-level assertions on the result channel of the decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module usd_checker
   import usd_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CP_W-1:0]   rsp_code_point,
   input logic [LEN_W-1:0]  rsp_seq_length,
   input logic [1:0]        rsp_status
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_code_point) && $stable(rsp_seq_length) && $stable(rsp_status), "result word changed while stalled")

   `ASSERT_SAME(a_err_zero, clock, reset, rsp_valid && rsp_status != STATUS_OK, rsp_code_point == '0 && rsp_seq_length == '0, "error result carries a value")

   `ASSERT_SAME(a_ok_len, clock, reset, rsp_valid && rsp_status == STATUS_OK, rsp_seq_length != '0 && rsp_seq_length <= MAX_SEQ_LEN, "ok result has a bad length")

   `ASSERT_SAME(a_ascii_range, clock, reset, rsp_valid && rsp_status == STATUS_OK && rsp_seq_length == 3'd1, rsp_code_point[CP_W-1:7] == '0, "one-byte result above seven bits")

endmodule

bind utf8_stream_decoder usd_checker u_usd_checker (.*);

/* tb/sv/utf8_decode_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 decode checker
// Watches the request and response channels of the stream decoder. It
// decodes every accepted word with its own copy of the sequence state, keeps
// the predicted results in order and compares each response word, field by
// field, with the oldest prediction.
// ---------------------------------------------------------------------------
module utf8_decode_checker
   import usd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_end_of_buffer,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [CP_W-1:0]  rsp_code_point,
   input  logic [LEN_W-1:0] rsp_seq_length,
   input  logic [1:0]       rsp_status,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [LEN_W-1:0] seq_length;
      status_type       status;
   } decode_result_type;

   decode_result_type expected_decodes[$];
   logic [CP_W-1:0]   partial_value = '0;
   logic [LEN_W-1:0]  bytes_left    = '0;
   logic [LEN_W-1:0]  seq_size      = '0;
   int                mismatches    = 0;

   task automatic clear_sequence();
      partial_value = '0;
      bytes_left    = '0;
      seq_size      = '0;
   endtask

   task automatic push_decode(input logic [CP_W-1:0] cp, input logic [LEN_W-1:0] len,
                              input status_type st);
      decode_result_type res;
      res.code_point = cp;
      res.seq_length = len;
      res.status     = st;
      expected_decodes.push_back(res);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
   endtask

   task automatic decode_word(input logic [7:0] b, input logic eob);
      logic [LEN_W-1:0] len;
      logic [CP_W-1:0]  payload;
      len     = '0;
      payload = '0;
      if (bytes_left != '0) begin
         // Continuation position: the low six bits are taken unchecked.
         partial_value = {partial_value[CP_W-7:0], b[5:0]};
         bytes_left    = bytes_left - 1'b1;
         if (bytes_left == '0) begin
            push_decode(partial_value, seq_size, STATUS_OK);
            clear_sequence();
         end else if (eob) begin
            push_decode('0, '0, STATUS_TRUNCATED);
            clear_sequence();
         end
      end else begin
         casez (b)
            8'b0???????: push_decode(CP_W'(b), 3'd1, STATUS_OK);
            8'b110?????: begin
               len     = 3'd2;
               payload = CP_W'(b[4:0]);
            end
            8'b1110????: begin
               len     = 3'd3;
               payload = CP_W'(b[3:0]);
            end
            8'b11110???: begin
               len     = 3'd4;
               payload = CP_W'(b[2:0]);
            end
            8'b111110??: begin
               len     = 3'd5;
               payload = CP_W'(b[1:0]);
            end
            8'b1111110?: begin
               len     = MAX_SEQ_LEN;
               payload = CP_W'(b[0]);
            end
            default: push_decode('0, '0, STATUS_BAD_LEAD);
         endcase
         if (len != '0) begin
            if (eob) begin
               push_decode('0, '0, STATUS_TRUNCATED);
               clear_sequence();
            end else begin
               partial_value = payload;
               bytes_left    = len - 1'b1;
               seq_size      = len;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      decode_result_type want;
      if (reset) begin
         expected_decodes.delete();
         clear_sequence();
      end else begin
         if (req_valid && req_ready) begin
            decode_word(req_in_byte, req_end_of_buffer);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_decodes.size() == 0) begin
               report_mismatch("unexpected word", '0,
                               {rsp_status, rsp_seq_length, rsp_code_point[26:0]});
            end else begin
               want = expected_decodes.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  report_mismatch("code_point", 32'(want.code_point), 32'(rsp_code_point));
               end
               if (rsp_seq_length !== want.seq_length) begin
                  report_mismatch("seq_length", 32'(want.seq_length), 32'(rsp_seq_length));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(want.status), 32'(rsp_status));
               end
            end
         end
      end
      fail_count    <= mismatches;
      pending_count <= expected_decodes.size();
   end

endmodule

/* tb/sv/tb_utf8_stream_decoder.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// UTF-8 stream decoder testbench
// Drives directed and random byte streams into the decoder, with bursty
// input and a stalling receiver that at one point holds off long enough to
// back up the input. A checker beside the decoder predicts and compares.
// ---------------------------------------------------------------------------
module tb_utf8_stream_decoder;
   import usd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int RANDOM_WORDS = 1050;
   localparam int HOLD_START   = 400;
   localparam int HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES  = 10;

   logic             clock             = 1'b0;
   logic             reset             = 1'b1;
   logic             req_valid         = 1'b0;
   logic             req_ready;
   logic [7:0]       req_in_byte       = '0;
   logic             req_end_of_buffer = 1'b0;
   logic             rsp_valid;
   logic             rsp_ready         = 1'b0;
   logic [CP_W-1:0]  rsp_code_point;
   logic [LEN_W-1:0] rsp_seq_length;
   logic [1:0]       rsp_status;
   int               fail_count;
   int               pending_count;
   int               cycle_count       = 0;
   int               words_sent        = 0;
   int               burst_left        = 0;

   utf8_stream_decoder u_top (.*);

   utf8_decode_checker u_checker (.*);

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   task automatic send_word(input logic [7:0] b, input logic eob);
      int gap;
      req_valid         <= 1'b1;
      req_in_byte       <= b;
      req_end_of_buffer <= eob;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic send_random_sequence();
      int         kind;
      int         len;
      int         cut;
      logic [7:0] lead;
      logic [7:0] b;
      logic [7:0] rand_bits;
      logic       eob;
      kind      = $urandom_range(0, 9);
      len       = $urandom_range(1, 6);
      rand_bits = 8'($urandom);
      if (kind == 9) begin
         send_word(rand_bits, 1'($urandom_range(0, 1)));
      end else begin
         if (kind == 8) begin
            len = $urandom_range(2, 6);
            cut = $urandom_range(1, len - 1);
         end else begin
            cut = len;
         end
         if (len == 1) begin
            lead = {1'b0, rand_bits[6:0]};
         end else begin
            lead = (8'hFF << (8 - len)) | (rand_bits & (8'hFF >> (len + 1)));
         end
         for (int i = 1; i <= cut; i++) begin
            if (i == 1) begin
               b = lead;
            end else if (kind == 7) begin
               b = 8'($urandom);
            end else begin
               b = {2'b10, 6'($urandom)};
            end
            if (i != cut) begin
               eob = 1'b0;
            end else if (kind == 8) begin
               eob = 1'b1;
            end else begin
               eob = ($urandom_range(0, 7) == 0);
            end
            send_word(b, eob);
         end
      end
   endtask

   initial begin : receiver
      int mode;
      int span;
      while (reset) @(posedge clock);
      repeat (HOLD_START) begin
         rsp_ready <= ($urandom_range(0, 3) != 0);
         @(posedge clock);
      end
      rsp_ready <= 1'b0;
      repeat (HOLD_CYCLES) @(posedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 60);
         repeat (span) begin
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(0, 1) == 1);
               2: rsp_ready <= ($urandom_range(0, 4) == 0);
               default: rsp_ready <= ~rsp_ready;
            endcase
            @(posedge clock);
         end
      end
   end

   initial begin : stimulus
      int random_target;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // One-byte code points at both ends, the second one at end of buffer.
      send_word(8'h00, 1'b0);
      send_word(8'h7F, 1'b1);
      // Invalid leads.
      send_word(8'h80, 1'b0);
      send_word(8'hBF, 1'b1);
      send_word(8'hFE, 1'b0);
      send_word(8'hFF, 1'b0);
      // Six-byte sequence giving the largest code point.
      send_word(8'hFD, 1'b0);
      repeat (5) send_word(8'hBF, 1'b0);
      // Truncated at the lead.
      send_word(8'hFC, 1'b1);
      // Two-byte sequence completed at end of buffer, with an unchecked byte.
      send_word(8'hC0, 1'b0);
      send_word(8'hFF, 1'b1);
      // Three-byte sequence truncated in the middle.
      send_word(8'hE0, 1'b0);
      send_word(8'h80, 1'b1);
      // Four-byte sequence with a lead-like byte in continuation position.
      send_word(8'hF7, 1'b0);
      send_word(8'hC1, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'h3F, 1'b0);
      // Five-byte sequence truncated on its fourth byte.
      send_word(8'hFB, 1'b0);
      send_word(8'h80, 1'b0);
      send_word(8'hBF, 1'b0);
      send_word(8'h80, 1'b1);

      random_target = words_sent + RANDOM_WORDS;
      while (words_sent < random_target) send_random_sequence();
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/usd_pkg.sv
rtl/utf8_stream_decoder.sv
rtl/usd_checker.sv
tb/sv/utf8_decode_checker.sv
tb/sv/tb_utf8_stream_decoder.sv
